/* rtl/static_linked_list_engine_defines.svh */
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle check
`define SLL_CHECK_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sll check failed");

// next-cycle check
`define SLL_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sll check failed");

`endif

/* rtl/sll_pkg.sv */
package sll_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int CFG_W    = 7;

  localparam int CAP_RESET = 64;

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    length;
  } res_t;

endpackage

/* rtl/sll_ram.sv */
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sll_seq.sv */
`include "static_linked_list_engine_defines.svh"

module sll_seq #(
  parameter int NODES     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sll_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sll_pkg::KIND_W-1:0]     kind_i,
  input  logic [sll_pkg::POS_W-1:0]      position_i,
  input  logic [sll_pkg::DATA_W-1:0]     data_in_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output sll_pkg::res_t                  res_o,
  output logic                           lk_re_o,
  output logic [$clog2(NODES+1)-1:0]     lk_raddr_o,
  output logic                           lk_we_o,
  output logic [$clog2(NODES+1)-1:0]     lk_waddr_o,
  output logic [$clog2(NODES+1)-1:0]     lk_wdata_o,
  input  logic [$clog2(NODES+1)-1:0]     lk_rdata_i,
  output logic                           wd_re_o,
  output logic [$clog2(NODES+1)-1:0]     wd_raddr_o,
  output logic                           wd_we_o,
  output logic [$clog2(NODES+1)-1:0]     wd_waddr_o,
  output logic [WORD_BITS-1:0]           wd_wdata_o,
  input  logic [WORD_BITS-1:0]           wd_rdata_i
);

  localparam int SW      = $clog2(NODES + 1);
  localparam int SW1     = SW + 1;
  localparam int PW      = sll_pkg::POS_W;
  localparam int CMPW    = (SW > PW) ? SW : PW;
  localparam int DW      = sll_pkg::DATA_W;
  localparam int LW      = sll_pkg::LEN_W;
  localparam int CAP_RST = (sll_pkg::CAP_RESET > NODES) ? NODES : sll_pkg::CAP_RESET;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_INS_LINK,
    S_INS_PREV,
    S_FETCH,
    S_GD,
    S_DEL_PUSH,
    S_DONE
  } state_e;

  state_e            state_q;
  sll_pkg::kind_e    op_q;
  sll_pkg::status_e  status_q;
  logic [DW-1:0]     data_q;
  logic [SW-1:0]     slot_q;
  logic [SW-1:0]     prev_q;
  logic [SW-1:0]     nxt_q;
  logic [SW-1:0]     obj_q;
  logic              use_rd_q;
  logic [CMPW-1:0]   rem_q;
  logic [SW-1:0]     first_q;
  logic [SW-1:0]     free_top_q;
  logic [SW-1:0]     stack_cnt_q;
  logic [SW-1:0]     fresh_q;
  logic [SW-1:0]     count_q;
  logic [SW-1:0]     cap_q;

  sll_pkg::kind_e    kind;
  logic              acc;
  logic              full;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   cnt_ext;
  logic [CMPW-1:0]   cap_ext;
  logic [CMPW-1:0]   ins_steps;
  logic [SW-1:0]     new_slot;
  logic              ins_go;
  logic [SW-1:0]     nxt_cur;
  logic [SW-1:0]     cap_d;

  always_comb begin
    kind      = sll_pkg::kind_e'(kind_i);
    acc       = in_valid_i && (state_q == S_IDLE);
    full      = count_q >= cap_q;
    pos_ext   = CMPW'(position_i);
    cnt_ext   = CMPW'(count_q);
    cap_ext   = CMPW'(cap_q);
    ins_steps = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;
    new_slot  = (stack_cnt_q != '0) ? free_top_q : fresh_q;
    ins_go    = acc && (kind == sll_pkg::OP_INSERT) && !full && !(pos_ext > cap_ext);
    nxt_cur   = use_rd_q ? lk_rdata_i : nxt_q;
    if (cfg_data_i == '0) begin
      cap_d = SW'(1);
    end else if (32'(cfg_data_i) > NODES) begin
      cap_d = SW'(NODES);
    end else begin
      cap_d = SW'(cfg_data_i);
    end
  end

  // memory ports
  always_comb begin
    lk_re_o    = 1'b0;
    lk_raddr_o = nxt_cur;
    lk_we_o    = 1'b0;
    lk_waddr_o = slot_q;
    lk_wdata_o = nxt_cur;
    wd_re_o    = 1'b0;
    wd_raddr_o = nxt_cur;
    wd_we_o    = ins_go;
    wd_waddr_o = new_slot;
    wd_wdata_o = WORD_BITS'(data_in_i);
    unique case (state_q)
      S_IDLE: begin
        lk_re_o    = ins_go && (stack_cnt_q != '0);
        lk_raddr_o = free_top_q;
      end
      S_WALK: begin
        lk_re_o = 1'b1;
      end
      S_INS_LINK: begin
        lk_we_o = 1'b1;
      end
      S_INS_PREV: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = prev_q;
        lk_wdata_o = slot_q;
      end
      S_FETCH: begin
        lk_re_o = 1'b1;
        wd_re_o = 1'b1;
      end
      S_GD: begin
        lk_we_o    = (op_q == sll_pkg::OP_DELETE) && (prev_q != '0);
        lk_waddr_o = prev_q;
        lk_wdata_o = lk_rdata_i;
      end
      S_DEL_PUSH: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = obj_q;
        lk_wdata_o = free_top_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= sll_pkg::OP_CLEAR;
      status_q    <= sll_pkg::ST_OK;
      data_q      <= '0;
      slot_q      <= '0;
      prev_q      <= '0;
      nxt_q       <= '0;
      obj_q       <= '0;
      use_rd_q    <= 1'b0;
      rem_q       <= '0;
      first_q     <= '0;
      free_top_q  <= '0;
      stack_cnt_q <= '0;
      fresh_q     <= SW'(1);
      count_q     <= '0;
      cap_q       <= SW'(CAP_RST);
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            op_q     <= kind;
            data_q   <= '0;
            status_q <= sll_pkg::ST_OK;
            prev_q   <= '0;
            nxt_q    <= first_q;
            use_rd_q <= 1'b0;
            state_q  <= S_DONE;
            unique case (kind)
              sll_pkg::OP_INSERT: begin
                if (full) begin
                  status_q <= sll_pkg::ST_FULL;
                end else if (pos_ext > cap_ext) begin
                  status_q <= sll_pkg::ST_RANGE;
                end else begin
                  slot_q  <= new_slot;
                  rem_q   <= ins_steps;
                  count_q <= count_q + SW'(1);
                  if (stack_cnt_q != '0) begin
                    stack_cnt_q <= stack_cnt_q - SW'(1);
                    state_q     <= S_POP;
                  end else begin
                    fresh_q <= fresh_q + SW'(1);
                    state_q <= (ins_steps == '0) ? S_INS_LINK : S_WALK;
                  end
                end
              end
              sll_pkg::OP_GET, sll_pkg::OP_DELETE: begin
                if (count_q == '0) begin
                  status_q <= sll_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                  status_q <= sll_pkg::ST_RANGE;
                end else begin
                  rem_q   <= pos_ext;
                  state_q <= (pos_ext == '0) ? S_FETCH : S_WALK;
                  if (kind == sll_pkg::OP_DELETE) begin
                    count_q <= count_q - SW'(1);
                  end
                end
              end
              sll_pkg::OP_CLEAR: begin
                first_q     <= '0;
                count_q     <= '0;
                fresh_q     <= SW'(1);
                stack_cnt_q <= '0;
              end
            endcase
          end
        end
        S_POP: begin
          free_top_q <= lk_rdata_i;
          state_q    <= (rem_q == '0) ? S_INS_LINK : S_WALK;
        end
        S_WALK: begin
          prev_q   <= nxt_cur;
          use_rd_q <= 1'b1;
          rem_q    <= rem_q - CMPW'(1);
          if (rem_q == CMPW'(1)) begin
            state_q <= (op_q == sll_pkg::OP_INSERT) ? S_INS_LINK : S_FETCH;
          end
        end
        S_INS_LINK: begin
          if (prev_q == '0) begin
            first_q <= slot_q;
            state_q <= S_DONE;
          end else begin
            state_q <= S_INS_PREV;
          end
        end
        S_INS_PREV: begin
          state_q <= S_DONE;
        end
        S_FETCH: begin
          obj_q   <= nxt_cur;
          state_q <= S_GD;
        end
        S_GD: begin
          data_q <= DW'(wd_rdata_i);
          if (op_q == sll_pkg::OP_DELETE) begin
            if (prev_q == '0) begin
              first_q <= lk_rdata_i;
            end
            state_q <= S_DEL_PUSH;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DEL_PUSH: begin
          free_top_q  <= obj_q;
          stack_cnt_q <= stack_cnt_q + SW'(1);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cfg_we_i) begin
        cap_q       <= cap_d;
        first_q     <= '0;
        count_q     <= '0;
        fresh_q     <= SW'(1);
        stack_cnt_q <= '0;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign res_o.status  = status_q;
  assign res_o.data    = data_q;
  assign res_o.length  = LW'(count_q);

  `SLL_CHECK_NOW(a_cap_range, 1'b1, (cap_q != '0) && (32'(cap_q) <= NODES))
  `SLL_CHECK_NOW(a_count_cap, 1'b1, count_q <= cap_q)
  `SLL_CHECK_NOW(a_free_balance, 1'b1, SW1'(stack_cnt_q) + SW1'(count_q) <= SW1'(cap_q))
  `SLL_CHECK_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE)
  `SLL_CHECK_NEXT(a_walk_end, (state_q == S_WALK) && (rem_q == CMPW'(1)), (state_q == S_INS_LINK) || (state_q == S_FETCH))

endmodule

/* rtl/static_linked_list_engine.sv */
// Linked list of words in slots 1..capacity with a free-slot stack; one word in, one word out
// for each operation (insert, get, delete, clear). Operations are taken one at a time, and the
// list is walked one link per cycle through the single read port of the link memory. Slots
// never used since the last clear are handed out by a counter, so no clearing pass follows
// reset or a clear. The result waits in an output register, and a write to the capacity
// register clears the list.
module static_linked_list_engine #(
  parameter int NODES     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sll_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sll_pkg::KIND_W-1:0]       kind_i,
  input  logic [sll_pkg::POS_W-1:0]        position_i,
  input  logic [sll_pkg::DATA_W-1:0]       data_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sll_pkg::STATUS_W-1:0]     status_o,
  output logic [sll_pkg::DATA_W-1:0]       data_out_o,
  output logic [sll_pkg::LEN_W-1:0]        list_length_o
);

  localparam int SW = $clog2(NODES + 1);

  logic                  lk_re;
  logic [SW-1:0]         lk_raddr;
  logic                  lk_we;
  logic [SW-1:0]         lk_waddr;
  logic [SW-1:0]         lk_wdata;
  logic [SW-1:0]         lk_rdata;
  logic                  wd_re;
  logic [SW-1:0]         wd_raddr;
  logic                  wd_we;
  logic [SW-1:0]         wd_waddr;
  logic [WORD_BITS-1:0]  wd_wdata;
  logic [WORD_BITS-1:0]  wd_rdata;

  logic                  res_valid;
  logic                  res_ready;
  sll_pkg::res_t         res;

  logic                  out_valid_q;
  sll_pkg::res_t         out_q;

  sll_ram #(
    .WIDTH (SW),
    .DEPTH (NODES + 1)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  sll_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NODES + 1)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wd_we),
    .waddr_i (wd_waddr),
    .wdata_i (wd_wdata),
    .re_i    (wd_re),
    .raddr_i (wd_raddr),
    .rdata_o (wd_rdata)
  );

  sll_seq #(
    .NODES     (NODES),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .lk_re_o     (lk_re),
    .lk_raddr_o  (lk_raddr),
    .lk_we_o     (lk_we),
    .lk_waddr_o  (lk_waddr),
    .lk_wdata_o  (lk_wdata),
    .lk_rdata_i  (lk_rdata),
    .wd_re_o     (wd_re),
    .wd_raddr_o  (wd_raddr),
    .wd_we_o     (wd_we),
    .wd_waddr_o  (wd_waddr),
    .wd_wdata_o  (wd_wdata),
    .wd_rdata_i  (wd_rdata)
  );

  // output word register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign data_out_o    = out_q.data;
  assign list_length_o = out_q.length;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES          = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef logic [sll_pkg::POS_W-1:0] slot_t;

  typedef struct packed {
    logic                       cfg;
    logic [sll_pkg::CFG_W-1:0]  cap;
    sll_pkg::kind_e             kind;
    slot_t                      pos;
    logic [sll_pkg::DATA_W-1:0] data;
    logic                       typed;
    sll_pkg::res_t              want;
  } step_t;

  localparam sll_pkg::res_t UNTYPED = '0;
  localparam int            NSTEPS  = 26;

  // directed sequence; starts at the reset capacity of 64
  localparam step_t STEPS [NSTEPS] = '{
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd0, 32'h0,
      1'b1, '{sll_pkg::ST_EMPTY, 32'h0, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd5, 32'h0,
      1'b1, '{sll_pkg::ST_EMPTY, 32'h0, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd65, 32'h0bad0bad,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd127, 32'hffffffff,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd64, 32'hffffffff,
      1'b1, '{sll_pkg::ST_OK, 32'h0, 7'd1}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd0, 32'h0,
      1'b1, '{sll_pkg::ST_OK, 32'h0, 7'd2}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd1, 32'h12345678, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd2, 32'h0,
      1'b1, '{sll_pkg::ST_OK, 32'hffffffff, 7'd3}},
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd3, 32'h0,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd3}},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd127, 32'h0,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd3}},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd1, 32'h0, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd1, 32'h0, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_CLEAR, 7'd127, 32'hffffffff,
      1'b1, '{sll_pkg::ST_OK, 32'h0, 7'd0}},
    '{1'b1, 7'd0, sll_pkg::OP_CLEAR, 7'd0, 32'h0, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd2, 32'h0,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd1, 32'ha5a5a5a5,
      1'b1, '{sll_pkg::ST_OK, 32'h0, 7'd1}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd0, 32'h0,
      1'b1, '{sll_pkg::ST_FULL, 32'h0, 7'd1}},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd127, 32'h0,
      1'b1, '{sll_pkg::ST_FULL, 32'h0, 7'd1}},
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd1, 32'h0,
      1'b1, '{sll_pkg::ST_RANGE, 32'h0, 7'd1}},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd0, 32'h0,
      1'b1, '{sll_pkg::ST_OK, 32'ha5a5a5a5, 7'd0}},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd0, 32'h0,
      1'b1, '{sll_pkg::ST_EMPTY, 32'h0, 7'd0}},
    '{1'b1, 7'd127, sll_pkg::OP_CLEAR, 7'd0, 32'h0, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd64, 32'h5a5a5a5a, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_INSERT, 7'd0, 32'h80000001, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_DELETE, 7'd1, 32'h0, 1'b0, UNTYPED},
    '{1'b0, 7'd0, sll_pkg::OP_GET, 7'd0, 32'h0, 1'b0, UNTYPED}
  };

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [sll_pkg::CFG_W-1:0]    cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [sll_pkg::KIND_W-1:0]   kind_i        = '0;
  logic [sll_pkg::POS_W-1:0]    position_i    = '0;
  logic [sll_pkg::DATA_W-1:0]   data_in_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [sll_pkg::STATUS_W-1:0] status_o;
  logic [sll_pkg::DATA_W-1:0]   data_out_o;
  logic [sll_pkg::LEN_W-1:0]    list_length_o;

  static_linked_list_engine #(
    .NODES    (NODES),
    .WORD_BITS(sll_pkg::DATA_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .data_in_i    (data_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .list_length_o(list_length_o)
  );

  always #5 clk_i = ~clk_i;

  // list model
  slot_t                      link_mem [0:NODES];
  logic [sll_pkg::DATA_W-1:0] word_mem [0:NODES];
  slot_t                      free_mem [0:NODES];
  slot_t                      head_slot;
  slot_t                      free_top;
  slot_t                      free_left;
  slot_t                      used;
  logic [sll_pkg::CFG_W-1:0]  cap_reg;

  sll_pkg::res_t pending_results [$];
  int            errors      = 0;
  int            idle_cycles = 0;
  int            sent_random = 0;
  bit            steady      = 1'b0;

  function automatic slot_t cap_now();
    if (cap_reg == '0) return slot_t'(1);
    if (int'(cap_reg) > NODES) return slot_t'(NODES);
    return cap_reg;
  endfunction

  function automatic slot_t next_slot(slot_t s);
    return (s == '0) ? head_slot : link_mem[s];
  endfunction

  function automatic void set_link(slot_t s, slot_t n);
    if (s == '0) head_slot = n;
    else link_mem[s] = n;
  endfunction

  function automatic slot_t slot_before(slot_t pos);
    slot_t prev;
    slot_t n;
    prev = '0;
    for (int i = 0; i < int'(pos); i++) begin
      n = next_slot(prev);
      if (n == '0) break;
      prev = n;
    end
    return prev;
  endfunction

  function automatic void clear_model();
    int c;
    c = int'(cap_now());
    for (int i = 0; i <= NODES; i++) free_mem[i] = '0;
    for (int i = 1; i < c; i++) free_mem[i] = slot_t'(i + 1);
    head_slot = '0;
    free_top  = slot_t'(1);
    free_left = slot_t'(c);
    used      = '0;
  endfunction

  function automatic sll_pkg::res_t apply_list_op(sll_pkg::kind_e k, slot_t pos,
                                                  logic [sll_pkg::DATA_W-1:0] d);
    sll_pkg::res_t r;
    slot_t         slot;
    slot_t         prev;
    slot_t         obj;
    r.status = sll_pkg::ST_OK;
    r.data   = '0;
    case (k)
      sll_pkg::OP_INSERT: begin
        if (free_left == '0 || used >= cap_now()) begin
          r.status = sll_pkg::ST_FULL;
        end else if (pos > cap_now()) begin
          r.status = sll_pkg::ST_RANGE;
        end else begin
          slot      = free_top;
          free_top  = free_mem[slot];
          free_left = free_left - 1'b1;
          if (free_left == '0) free_top = '0;
          word_mem[slot] = d;
          prev = slot_before(pos);
          set_link(slot, next_slot(prev));
          set_link(prev, slot);
          used = used + 1'b1;
        end
      end
      sll_pkg::OP_GET, sll_pkg::OP_DELETE: begin
        if (used == '0) begin
          r.status = sll_pkg::ST_EMPTY;
        end else if (pos >= used) begin
          r.status = sll_pkg::ST_RANGE;
        end else begin
          prev   = slot_before(pos);
          obj    = next_slot(prev);
          r.data = word_mem[obj];
          if (k == sll_pkg::OP_DELETE) begin
            set_link(prev, next_slot(obj));
            link_mem[obj] = '0;
            free_mem[obj] = (free_left == '0) ? '0 : free_top;
            free_top      = obj;
            free_left     = free_left + 1'b1;
            used          = used - 1'b1;
          end
        end
      end
      default: clear_model();
    endcase
    r.length = used;
    return r;
  endfunction

  function automatic void report(string what, sll_pkg::res_t want, sll_pkg::res_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: want st %0d data %h len %0d, got st %0d data %h len %0d", $realtime,
               what, want.status, want.data, want.length, got.status, got.data, got.length);
  endfunction

  task automatic send_word(input sll_pkg::kind_e k, input slot_t p,
                           input logic [sll_pkg::DATA_W-1:0] d,
                           input bit typed, input sll_pkg::res_t want);
    sll_pkg::res_t r;
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    position_i <= p;
    data_in_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_list_op(k, p, d);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic set_capacity(input logic [sll_pkg::CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
    clear_model();
  endtask

  task automatic run_phase(input logic [sll_pkg::CFG_W-1:0] cap_val, input int count);
    sll_pkg::kind_e             k;
    slot_t                      p;
    logic [sll_pkg::DATA_W-1:0] d;
    bit                         filling;
    int                         r;
    int                         ins;
    set_capacity(cap_val);
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      steady = (sent_random >= 700 && sent_random < 1000);
      case ($urandom_range(0, 9))
        0:       d = '0;
        1:       d = '1;
        default: d = $urandom;
      endcase
      if (used == cap_now()) begin
        if ($urandom_range(0, 3) == 0) filling = 1'b0;
      end else if (used == '0) begin
        filling = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        k = sll_pkg::OP_CLEAR;
        p = slot_t'($urandom_range(0, 127));
      end else if (r < 8) begin
        k = sll_pkg::kind_e'($urandom_range(0, 3));
        p = slot_t'($urandom_range(0, 127));
      end else begin
        ins = filling ? 55 : 20;
        r   = $urandom_range(0, 99);
        if (r < ins) begin
          k = sll_pkg::OP_INSERT;
          if ($urandom_range(0, 9) == 0) p = slot_t'($urandom_range(0, int'(cap_now())));
          else p = slot_t'($urandom_range(0, int'(used)));
        end else begin
          k = (r < ins + 25) ? sll_pkg::OP_GET : sll_pkg::OP_DELETE;
          p = (used == '0) ? '0 : slot_t'($urandom_range(0, int'(used) - 1));
        end
      end
      send_word(k, p, d, 1'b0, UNTYPED);
      sent_random++;
    end
  endtask

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(0, 99) < 25);

  always @(posedge clk_i) begin : check_results
    sll_pkg::res_t got;
    sll_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = sll_pkg::status_e'(status_o);
      got.data   = data_out_o;
      got.length = list_length_o;
      if (pending_results.size() == 0) begin
        report("unexpected word", UNTYPED, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.length !== want.length)
          report("mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i <= NODES; i++) begin
      link_mem[i] = '0;
      word_mem[i] = '0;
    end
    cap_reg = sll_pkg::CFG_W'(sll_pkg::CAP_RESET);
    clear_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NSTEPS; i++) begin
      if (STEPS[i].cfg) set_capacity(STEPS[i].cap);
      else send_word(STEPS[i].kind, STEPS[i].pos, STEPS[i].data, STEPS[i].typed, STEPS[i].want);
    end

    run_phase(7'd5, 205);
    run_phase(7'd1, 205);
    run_phase(7'd64, 205);
    run_phase(7'd0, 205);
    run_phase(7'd127, 205);
    run_phase(7'd2, 205);
    run_phase(sll_pkg::CFG_W'($urandom_range(3, 63)), 205);
    run_phase(7'd33, 205);

    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NODES + 8) @(posedge clk_i);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* static_linked_list_engine.f */
+incdir+rtl
rtl/sll_pkg.sv
rtl/sll_ram.sv
rtl/sll_seq.sv
rtl/static_linked_list_engine.sv
tb/sv/tb_top.sv
